/* hw/rtl/backing_store_map_table_core_macros.svh */
// assertion helpers for the backing store map table
`ifndef BACKING_STORE_MAP_TABLE_CORE_MACROS_SVH
`define BACKING_STORE_MAP_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// checked on every clock edge outside reset
`define BSMT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bsmt assertion failed");

// checked on every clock edge, reset included
`define BSMT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bsmt assertion failed");

`else

`define BSMT_ASSERT(lbl, prop)
`define BSMT_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

/* hw/rtl/bsmt_pkg.sv */
package bsmt_pkg;

  localparam int unsigned NumStores     = 16;
  localparam int unsigned NumProcs      = 64;
  localparam int unsigned PagesPerStore = 256;

  localparam int unsigned StoreW   = (NumStores > 1) ? $clog2(NumStores) : 1;
  localparam int unsigned ProcW    = (NumProcs > 1) ? $clog2(NumProcs) : 1;
  localparam int unsigned AddrW    = StoreW + ProcW;
  localparam int unsigned RamDepth = 2 ** AddrW;
  localparam int unsigned CntW     = $clog2(NumStores + 1);

  localparam int unsigned CmdW       = 3;
  localparam int unsigned ProcIdW    = 6;
  localparam int unsigned VaddrW     = 32;
  localparam int unsigned PageW      = 20;
  localparam int unsigned PageShift  = 12;
  localparam int unsigned StoreInW   = 4;
  localparam int unsigned PagesW     = 9;
  localparam int unsigned MappersW   = 7;
  localparam int unsigned StoreOutW  = 4;
  localparam int unsigned OffsetW    = 8;

  localparam logic [MappersW-1:0] MappersMax   = 7'd127;
  localparam logic [PageW-1:0]    MinPageReset = 20'd4096;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_MAP    = 3'd3,
    CMD_UNMAP  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             mapped;
    logic [PageW-1:0] base;
  } map_entry_t;

  localparam int unsigned EntryW = $bits(map_entry_t);

endpackage

/* hw/rtl/bsmt_ram.sv */
module bsmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/backing_store_map_table_core.sv */
// Backing store map table. Commands come in on the item input (allocate, free, lookup, map,
// unmap) and each gives one result item (status, store, page offset). The per-process window
// records sit in a RAM with one write port and one registered read port, addressed by
// {store, process}; after reset a clearing pass over all 1024 entries (one entry per cycle
// over every store/process pair) runs before the first item is taken, while min_virtual_page
// writes are taken at any time. Free, map and rejected commands pass from acceptance through
// the EXEC and DONE states to the result. Allocate, lookup and unmap walk the stores in index
// order, one store per cycle through the registered RAM read port, and stop at the first hit
// or after the last store when nothing matches. A finished result sits in the output register
// while the next item is accepted.
`include "backing_store_map_table_core_macros.svh"

module backing_store_map_table_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bsmt_pkg::PageW-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bsmt_pkg::CmdW-1:0]          cmd_i,
  input  logic [bsmt_pkg::ProcIdW-1:0]       proc_id_i,
  input  logic [bsmt_pkg::VaddrW-1:0]        virt_addr_i,
  input  logic [bsmt_pkg::PageW-1:0]         virt_page_i,
  input  logic [bsmt_pkg::StoreInW-1:0]      store_in_i,
  input  logic [bsmt_pkg::PagesW-1:0]        page_count_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               status_o,
  output logic [bsmt_pkg::StoreOutW-1:0]     store_out_o,
  output logic [bsmt_pkg::OffsetW-1:0]       page_offset_o
);

  bsmt_pkg::state_e state_q, state_d;

  logic [bsmt_pkg::CmdW-1:0]     cmd_q, cmd_d;
  logic [bsmt_pkg::ProcIdW-1:0]  pid_q, pid_d;
  logic [bsmt_pkg::VaddrW-1:0]   vaddr_q, vaddr_d;
  logic [bsmt_pkg::PageW-1:0]    vpage_q, vpage_d;
  logic [bsmt_pkg::StoreInW-1:0] st_q, st_d;
  logic [bsmt_pkg::PagesW-1:0]   npg_q, npg_d;

  logic [bsmt_pkg::PageW-1:0] min_page_q;

  logic [bsmt_pkg::NumStores-1:0] alloc_q, alloc_d;
  logic [bsmt_pkg::PagesW-1:0]    pages_q [bsmt_pkg::NumStores];
  logic [bsmt_pkg::PagesW-1:0]    pages_d [bsmt_pkg::NumStores];
  logic [bsmt_pkg::MappersW-1:0]  mappers_q [bsmt_pkg::NumStores];
  logic [bsmt_pkg::MappersW-1:0]  mappers_d [bsmt_pkg::NumStores];

  logic [bsmt_pkg::AddrW-1:0]  clr_q, clr_d;
  logic [bsmt_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        pend_q, pend_d;
  logic [bsmt_pkg::StoreW-1:0] pend_idx_q, pend_idx_d;

  logic                           res_status_q, res_status_d;
  logic [bsmt_pkg::StoreOutW-1:0] res_store_q, res_store_d;
  logic [bsmt_pkg::OffsetW-1:0]   res_off_q, res_off_d;

  logic                           out_valid_q, out_valid_d;
  logic                           status_q, status_d;
  logic [bsmt_pkg::StoreOutW-1:0] store_q, store_d;
  logic [bsmt_pkg::OffsetW-1:0]   off_q, off_d;

  logic                        ram_we;
  logic [bsmt_pkg::AddrW-1:0]  ram_waddr;
  logic [bsmt_pkg::AddrW-1:0]  ram_raddr;
  logic [bsmt_pkg::EntryW-1:0] ram_wdata;
  logic [bsmt_pkg::EntryW-1:0] ram_rdata;
  bsmt_pkg::map_entry_t        rd_entry;
  bsmt_pkg::map_entry_t        wr_entry;

  logic                          pid_ok, st_ok, npg_ok, vp_ok, scan_cmd;
  logic [bsmt_pkg::ProcW-1:0]    pid_idx;
  logic [bsmt_pkg::StoreW-1:0]   st_idx;
  logic [bsmt_pkg::PageW-1:0]    scan_vp;
  logic [bsmt_pkg::PageW:0]      win_end;
  logic                          win_hit, match, hit, miss_end;
  logic [bsmt_pkg::MappersW-1:0] m_cur, m_dec;

  // map RAM: {mapped, base page} per store/process pair

  bsmt_ram #(
    .Width(bsmt_pkg::EntryW),
    .Depth(bsmt_pkg::RamDepth)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = bsmt_pkg::map_entry_t'(ram_rdata);

  // command checks

  assign pid_ok  = int'(pid_q) < bsmt_pkg::NumProcs;
  assign st_ok   = int'(st_q) < bsmt_pkg::NumStores;
  assign npg_ok  = (npg_q != '0) && (int'(npg_q) <= bsmt_pkg::PagesPerStore);
  assign vp_ok   = vpage_q >= min_page_q;
  assign pid_idx = bsmt_pkg::ProcW'(pid_q);
  assign st_idx  = bsmt_pkg::StoreW'(st_q);

  assign scan_cmd = (cmd_q == bsmt_pkg::CMD_ALLOC) ||
                    ((cmd_q == bsmt_pkg::CMD_LOOKUP) && pid_ok) ||
                    ((cmd_q == bsmt_pkg::CMD_UNMAP) && pid_ok && vp_ok);

  // shared window compare

  assign scan_vp  = (cmd_q == bsmt_pkg::CMD_LOOKUP) ?
                    vaddr_q[bsmt_pkg::VaddrW-1:bsmt_pkg::PageShift] : vpage_q;
  assign win_end  = {1'b0, rd_entry.base} + (bsmt_pkg::PageW + 1)'(pages_q[pend_idx_q]);
  assign win_hit  = rd_entry.mapped && (scan_vp >= rd_entry.base) &&
                    ({1'b0, scan_vp} < win_end);
  assign match    = (cmd_q == bsmt_pkg::CMD_ALLOC) ? !alloc_q[pend_idx_q] : win_hit;
  assign hit      = pend_q && match;
  assign miss_end = pend_q && !match &&
                    (cnt_q == bsmt_pkg::CntW'(bsmt_pkg::NumStores));

  assign m_cur = mappers_q[pend_idx_q];
  assign m_dec = (m_cur != '0) ? m_cur - 1'b1 : '0;

  // next state

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsmt_pkg::ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = bsmt_pkg::ST_IDLE;
        end
      end
      bsmt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bsmt_pkg::ST_EXEC;
        end
      end
      bsmt_pkg::ST_EXEC: begin
        state_d = scan_cmd ? bsmt_pkg::ST_SCAN : bsmt_pkg::ST_DONE;
      end
      bsmt_pkg::ST_SCAN: begin
        if (hit || miss_end) begin
          state_d = bsmt_pkg::ST_DONE;
        end
      end
      bsmt_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = bsmt_pkg::ST_IDLE;
        end
      end
      default: state_d = bsmt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs

  always_comb begin
    cmd_d        = cmd_q;
    pid_d        = pid_q;
    vaddr_d      = vaddr_q;
    vpage_d      = vpage_q;
    st_d         = st_q;
    npg_d        = npg_q;
    alloc_d      = alloc_q;
    pages_d      = pages_q;
    mappers_d    = mappers_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    res_status_d = res_status_q;
    res_store_d  = res_store_q;
    res_off_d    = res_off_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    store_d      = store_q;
    off_d        = off_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    wr_entry     = '0;
    ram_raddr    = {bsmt_pkg::StoreW'(cnt_q), pid_idx};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bsmt_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      bsmt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          pid_d   = proc_id_i;
          vaddr_d = virt_addr_i;
          vpage_d = virt_page_i;
          st_d    = store_in_i;
          npg_d   = page_count_i;
          cnt_d   = '0;
          pend_d  = 1'b0;
        end
      end
      bsmt_pkg::ST_EXEC: begin
        res_status_d = 1'b1;
        res_store_d  = '0;
        res_off_d    = '0;
        unique case (cmd_q)
          bsmt_pkg::CMD_FREE: begin
            if (st_ok) begin
              alloc_d[st_idx] = 1'b0;
              res_status_d    = 1'b0;
            end
          end
          bsmt_pkg::CMD_MAP: begin
            if (pid_ok && vp_ok && st_ok && npg_ok) begin
              ram_we          = 1'b1;
              ram_waddr       = {st_idx, pid_idx};
              wr_entry.mapped = 1'b1;
              wr_entry.base   = vpage_q;
              if (mappers_q[st_idx] < bsmt_pkg::MappersMax) begin
                mappers_d[st_idx] = mappers_q[st_idx] + 1'b1;
              end
              if (pages_q[st_idx] == '0) begin
                pages_d[st_idx] = npg_q;
              end
              res_status_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      bsmt_pkg::ST_SCAN: begin
        if (cnt_q < bsmt_pkg::CntW'(bsmt_pkg::NumStores)) begin
          cnt_d      = cnt_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = bsmt_pkg::StoreW'(cnt_q);
        end else begin
          pend_d = 1'b0;
        end
        if (hit) begin
          res_status_d = 1'b0;
          unique case (cmd_q)
            bsmt_pkg::CMD_ALLOC: begin
              alloc_d[pend_idx_q] = 1'b1;
              res_store_d         = bsmt_pkg::StoreOutW'(pend_idx_q);
            end
            bsmt_pkg::CMD_LOOKUP: begin
              res_store_d = bsmt_pkg::StoreOutW'(pend_idx_q);
              res_off_d   = bsmt_pkg::OffsetW'(scan_vp - rd_entry.base);
            end
            bsmt_pkg::CMD_UNMAP: begin
              ram_we                = 1'b1;
              ram_waddr             = {pend_idx_q, pid_idx};
              wr_entry.mapped       = 1'b0;
              wr_entry.base         = rd_entry.base;
              mappers_d[pend_idx_q] = m_dec;
              if (m_dec == '0) begin
                pages_d[pend_idx_q] = '0;
                alloc_d[pend_idx_q] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      bsmt_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          store_d     = res_status_q ? '0 : res_store_q;
          off_d       = res_status_q ? '0 : res_off_q;
        end
      end
      default: ;
    endcase
  end

  assign ram_wdata = wr_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsmt_pkg::ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      alloc_q     <= '0;
      for (int i = 0; i < bsmt_pkg::NumStores; i++) begin
        pages_q[i]   <= '0;
        mappers_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      alloc_q     <= alloc_d;
      pages_q     <= pages_d;
      mappers_q   <= mappers_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_page_q <= bsmt_pkg::MinPageReset;
    end else if (cfg_we_i) begin
      min_page_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pid_q        <= pid_d;
    vaddr_q      <= vaddr_d;
    vpage_q      <= vpage_d;
    st_q         <= st_d;
    npg_q        <= npg_d;
    pend_idx_q   <= pend_idx_d;
    res_status_q <= res_status_d;
    res_store_q  <= res_store_d;
    res_off_q    <= res_off_d;
    status_q     <= status_d;
    store_q      <= store_d;
    off_q        <= off_d;
  end

  assign in_ready_o    = (state_q == bsmt_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign store_out_o   = store_q;
  assign page_offset_o = off_q;

  // checks

  `BSMT_ASSERT(accept_to_exec_a, in_valid_i && in_ready_o |=> state_q == bsmt_pkg::ST_EXEC)
  `BSMT_ASSERT(done_loads_out_a,
    (state_q == bsmt_pkg::ST_DONE) && (!out_valid_q || out_ready_i) |=> out_valid_q)
  `BSMT_ASSERT(scan_cnt_range_a,
    state_q == bsmt_pkg::ST_SCAN |-> cnt_q <= bsmt_pkg::CntW'(bsmt_pkg::NumStores))
  `BSMT_ASSERT_ALWAYS(clear_blocks_input_a,
    (state_q == bsmt_pkg::ST_CLEAR) |-> !in_ready_o && ram_we)

endmodule
